// File: rtl/tpc_pkg.sv
// constants shared by the truncated pmf convolver
// field widths, opcodes, vector size and fixed-point scaling; no dependencies
package tpc_pkg;

    localparam int VECTOR_LEN = 256;
    localparam int FRAC_BITS  = 15;

    localparam int OP_W   = 2;
    localparam int IDX_W  = 8;
    localparam int PROB_W = 16;

    localparam int ADDR_W = $clog2(VECTOR_LEN);

    localparam int ACC_W_MAC = 2 * PROB_W + ADDR_W;
    localparam int ACC_W_CMP = 2 * FRAC_BITS + 2;
    localparam int ACC_W     = (ACC_W_MAC > ACC_W_CMP) ? ACC_W_MAC : ACC_W_CMP;

    localparam logic [ACC_W-1:0] HALF_LSB  = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic [ACC_W-1:0] ONE_ACC   = ACC_W'(1) << FRAC_BITS;
    localparam logic [ACC_W-1:0] SAT_LIMIT = ACC_W'(1) << (2 * FRAC_BITS);

    localparam logic [OP_W-1:0] OP_LOAD_FIRST  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_SECOND = 2'd1;
    localparam logic [OP_W-1:0] OP_READ        = 2'd2;

endpackage

// File: rtl/truncated_pmf_convolver.sv
// truncated linear convolution of two probability vectors held in local memories
// one shared multiply-accumulate unit under a small sequencer; depends on tpc_pkg
//
//   channel  ports                                   role
//   s_       opcode, entry_index, prob_value         load entry or request entry k
//   m_       out_index, out_prob, saturated          one result per read transaction
//
// a load writes its entry into memory; a read of index k issues k+1 multiply-accumulates,
// one per cycle through the shared multiplier, and its terms then pass through the
// memory read, multiply and accumulate registers before the result is formed
// s_ready is low while a read is computing; a finished result waits in the
// output register while new transactions are taken
// vector memories are not cleared by reset and hold nothing until loaded
module truncated_pmf_convolver
    import tpc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_opcode,
    input  logic [IDX_W-1:0]  s_entry_index,
    input  logic [PROB_W-1:0] s_prob_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [IDX_W-1:0]  m_out_index,
    output logic [PROB_W-1:0] m_out_prob,
    output logic              m_saturated
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    logic [PROB_W-1:0] first_mem  [VECTOR_LEN];
    logic [PROB_W-1:0] second_mem [VECTOR_LEN];

    state_t              state_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [ADDR_W-1:0]   cnt_reg;
    logic                rd_vld_reg;
    logic                prod_vld_reg;
    logic [PROB_W-1:0]   a_rd_reg;
    logic [PROB_W-1:0]   b_rd_reg;
    logic [2*PROB_W-1:0] prod_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic                m_valid_reg;
    logic [IDX_W-1:0]    m_out_index_reg;
    logic [PROB_W-1:0]   m_out_prob_reg;
    logic                m_saturated_reg;

    logic              s_fire;
    logic              in_range;
    logic              wr_first;
    logic              wr_second;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] k_addr;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic              issue;
    logic              last_issue;
    logic              pipe_empty;
    logic              finish;
    logic [ACC_W-1:0]  acc_rnd;
    logic              sat_flag;
    logic [PROB_W-1:0] rnd_prob;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign in_range   = (32'(s_entry_index) < VECTOR_LEN);
    assign wr_addr    = ADDR_W'(s_entry_index);
    assign wr_first   = s_fire && (s_opcode == OP_LOAD_FIRST) && in_range;
    assign wr_second  = s_fire && (s_opcode == OP_LOAD_SECOND) && in_range;

    assign k_addr     = ADDR_W'(idx_reg);
    assign addr_a     = cnt_reg;
    assign addr_b     = k_addr - cnt_reg;
    assign issue      = (state_reg == ST_RUN);
    assign last_issue = issue && (cnt_reg == k_addr);
    assign pipe_empty = !rd_vld_reg && !prod_vld_reg;
    assign finish     = (state_reg == ST_DRAIN) && pipe_empty && (!m_valid_reg || m_ready);

    // round half up, clamp at 1.0
    assign acc_rnd  = acc_reg + HALF_LSB;
    assign sat_flag = (acc_reg > SAT_LIMIT);
    assign rnd_prob = sat_flag ? ONE_ACC[PROB_W-1:0] : PROB_W'(acc_rnd >> FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (wr_first) begin
            first_mem[wr_addr] <= s_prob_value;
        end
        if (wr_second) begin
            second_mem[wr_addr] <= s_prob_value;
        end
        a_rd_reg <= first_mem[addr_a];
        b_rd_reg <= second_mem[addr_b];
        prod_reg <= a_rd_reg * b_rd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            rd_vld_reg   <= issue;
            prod_vld_reg <= rd_vld_reg;
            if (prod_vld_reg) begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
            if (m_valid_reg && m_ready && !finish) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire && (s_opcode == OP_READ)) begin
                        idx_reg <= s_entry_index;
                        cnt_reg <= '0;
                        acc_reg <= '0;
                        state_reg <= in_range ? ST_RUN : ST_DRAIN;
                    end
                end
                ST_RUN: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (last_issue) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (finish) begin
                        m_valid_reg     <= 1'b1;
                        m_out_index_reg <= idx_reg;
                        m_out_prob_reg  <= rnd_prob;
                        m_saturated_reg <= sat_flag;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_index = m_out_index_reg;
    assign m_out_prob  = m_out_prob_reg;
    assign m_saturated = m_saturated_reg;

    // multiply stage only follows a memory read
    a_prod_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        prod_vld_reg |-> $past(rd_vld_reg))
        else $error("product valid without preceding read");

    // no new transaction while the mac pipeline still holds terms
    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> pipe_empty)
        else $error("accepting while mac pipeline busy");

    // a clamped result carries exactly 1.0
    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |-> (m_out_prob == ONE_ACC[PROB_W-1:0]))
        else $error("saturated result not equal to 1.0");

    // a result is loaded only from the drain state
    a_result_from_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DRAIN))
        else $error("result raised outside drain");

    // issue counter never runs past the requested index
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |-> (cnt_reg <= k_addr))
        else $error("issue counter beyond index");

endmodule
